>>> hw/rtl/qwcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwcf_pkg: shared types and constants of the colour fusion unit
// Field widths, action codes and the reset value of a store entry.
// ----------------------------------------------------------------------------
package qwcf_pkg;

	localparam int IDX_W  = 16;
	localparam int CH_W   = 8;
	localparam int QUAL_W = 16;
	localparam int BW_W   = 15;
	localparam int ACT_W  = 2;
	localparam int WGT_W  = 16;   // Q0.16 weight, strictly inside (0, 1)

	typedef logic [CH_W-1:0]          chan_t;
	typedef logic signed [QUAL_W-1:0] qual_t;
	typedef logic [ACT_W-1:0]         act_t;

	localparam act_t ACT_IGNORED  = 2'd0;
	localparam act_t ACT_BLENDED  = 2'd1;
	localparam act_t ACT_REPLACED = 2'd2;

	// never-coloured point
	localparam qual_t QUALITY_MIN = 16'sh8000;

	// one store entry: colour in the upper bits, quality below
	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		qual_t q;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{r: '0, g: '0, b: '0, q: QUALITY_MIN};

endpackage

>>> hw/rtl/qwcf_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwcf_sample_if: sample channel
// Valid/ready channel carrying one coloured sample word.
// ----------------------------------------------------------------------------
interface qwcf_sample_if;
	import qwcf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         point_index;
	chan_t                    red;
	chan_t                    green;
	chan_t                    blue;
	qual_t                    quality;

	modport source (output valid, point_index, red, green, blue, quality, input ready);
	modport sink   (input valid, point_index, red, green, blue, quality, output ready);
endinterface

>>> hw/rtl/qwcf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwcf_result_if: result channel
// Valid/ready channel carrying the action and the point contents afterwards.
// ----------------------------------------------------------------------------
interface qwcf_result_if;
	import qwcf_pkg::*;

	logic  valid;
	logic  ready;
	act_t  action;
	chan_t out_red;
	chan_t out_green;
	chan_t out_blue;
	qual_t out_quality;

	modport source (output valid, action, out_red, out_green, out_blue, out_quality,
		input ready);
	modport sink   (input valid, action, out_red, out_green, out_blue, out_quality,
		output ready);
endinterface

>>> hw/rtl/quality_weighted_color_fusion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_weighted_color_fusion_unit: per-point colour fusion
// Read-modify-write of a colour/quality store with an iterative blend weight.
// ----------------------------------------------------------------------------
// Keeps an RGB colour and a signed quality for each of NUM_POINTS points and
// fuses one sample word per accepted input. A negative quality is ignored; a
// quality within blend_width of the stored one blends the colours (stored
// quality kept); otherwise a better quality replaces colour and quality.
// Every sample yields exactly one result word: the action and the point's
// contents after the update. An index at or beyond NUM_POINTS stores nothing
// and returns black with minimum quality. After reset the store is swept
// clear, one entry per cycle, so the sample channel stays not ready until
// the sweep ends; blend_width writes are taken during that sweep too.
// Steps per word: accept, store read, decision, then either the finish
// state (ignore/replace) or the restoring divider for the Q0.16 weight
// followed by the shared channel multiplier on red, green and blue in turn
// and then the finish state (blend). No new sample is accepted before the
// current word is finished. A finished word sits in the output register
// while the next sample is accepted; a second one waits for it to drain.
// ----------------------------------------------------------------------------
module quality_weighted_color_fusion_unit #(
	parameter int NUM_POINTS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [qwcf_pkg::BW_W-1:0]  cfg_wr_data,
	qwcf_sample_if.sink                sample,
	qwcf_result_if.source              result
);
	import qwcf_pkg::*;

	localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int DIV_STEPS = WGT_W;
	localparam int CW = $clog2(DIV_STEPS);

	// sequencer, one-hot
	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_EVAL  = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_MIX   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [BW_W-1:0] bw_q;

	// captured sample
	logic [AW-1:0] addr_q;
	logic          in_range_q;
	chan_t         smp_r_q, smp_g_q, smp_b_q;
	qual_t         smp_q_q;

	// store
	entry_t        mem [NUM_POINTS];
	entry_t        rd_q;
	logic [AW-1:0] clr_addr_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	// pending result and whether it goes back to the store
	act_t          res_act_q;
	chan_t         res_ch_q [3];
	qual_t         res_q_q;
	logic          res_wr_q;

	// divider and mixer
	logic [WGT_W-1:0] rem_q;
	logic [WGT_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic [1:0]       ch_q;

	// output register
	logic  out_valid_q;
	act_t  out_act_q;
	chan_t out_r_q, out_g_q, out_b_q;
	qual_t out_qual_q;

	// ---------------------------------------------------------------- decision
	logic signed [QUAL_W:0]   dq;
	logic [QUAL_W:0]          adq;
	logic                     in_band;
	logic signed [QUAL_W+1:0] num;

	always_comb begin
		dq      = {smp_q_q[QUAL_W-1], smp_q_q} - {rd_q.q[QUAL_W-1], rd_q.q};
		adq     = dq[QUAL_W] ? 17'(-dq) : 17'(dq);
		in_band = adq < {2'b00, bw_q};
		// dq + bw lies in (0, 2bw), so it fits the weight width
		num     = 18'(dq) + 18'(signed'({3'b000, bw_q}));
	end

	// ------------------------------------------------ restoring divider step
	// w2 = floor(num * 2^16 / (2 * bw)); num < 2bw so one quotient bit a step
	logic [WGT_W-1:0] dvs;
	logic [WGT_W:0]   rem_sh;
	logic             q_bit;
	logic [WGT_W:0]   rem_sub;

	always_comb begin
		dvs     = {bw_q, 1'b0};
		rem_sh  = {rem_q, 1'b0};
		q_bit   = rem_sh >= {1'b0, dvs};
		rem_sub = rem_sh - {1'b0, dvs};
	end

	// ------------------------------------------------- shared channel mixer
	// old*w1 + new*w2 + half  ==  old*2^16 + (new - old)*w2 + half
	chan_t                    mix_old;
	chan_t                    mix_new;
	logic signed [CH_W:0]     mix_diff;
	logic signed [25:0]       mix_prod;
	logic signed [25:0]       mix_acc;

	always_comb begin
		case (ch_q)
			2'd0: begin
				mix_old = rd_q.r;
				mix_new = smp_r_q;
			end
			2'd1: begin
				mix_old = rd_q.g;
				mix_new = smp_g_q;
			end
			2'd2: begin
				mix_old = rd_q.b;
				mix_new = smp_b_q;
			end
			default: begin
				mix_old = '0;
				mix_new = '0;
			end
		endcase
		mix_diff = signed'({1'b0, mix_new}) - signed'({1'b0, mix_old});
		mix_prod = 26'(mix_diff) * 26'(signed'({1'b0, quo_q}));
		mix_acc  = signed'(26'({mix_old, 16'h0000})) + mix_prod + 26'sd32768;
	end

	// ----------------------------------------------------------- store port
	logic done_go;

	assign done_go = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '{r: res_ch_q[0], g: res_ch_q[1], b: res_ch_q[2], q: res_q_q};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = ENTRY_RESET;
		end else if (done_go && res_wr_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[addr_q];
	end

	// ------------------------------------------------------------- handshake
	assign sample.ready       = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.action      = out_act_q;
	assign result.out_red     = out_r_q;
	assign result.out_green   = out_g_q;
	assign result.out_blue    = out_b_q;
	assign result.out_quality = out_qual_q;

	// ------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= '0;
		end else if (cfg_wr_en) begin
			bw_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			res_wr_q    <= 1'b0;
			cnt_q       <= '0;
			ch_q        <= '0;
		end else begin
			if (result.ready && out_valid_q && !done_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(NUM_POINTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (sample.valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					res_wr_q <= 1'b0;
					state_q  <= ST_DONE;
					if (in_range_q && !smp_q_q[QUAL_W-1]) begin
						if (in_band) begin
							res_wr_q <= 1'b1;
							cnt_q    <= '0;
							state_q  <= ST_DIV;
						end else if (smp_q_q > rd_q.q) begin
							res_wr_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						ch_q    <= '0;
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == 2'd2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			addr_q     <= AW'(sample.point_index);
			in_range_q <= 32'(sample.point_index) < NUM_POINTS;
			smp_r_q    <= sample.red;
			smp_g_q    <= sample.green;
			smp_b_q    <= sample.blue;
			smp_q_q    <= sample.quality;
		end

		if (state_q == ST_EVAL) begin
			rem_q <= num[WGT_W-1:0];
			quo_q <= '0;
			if (!in_range_q) begin
				res_act_q   <= ACT_IGNORED;
				res_ch_q[0] <= '0;
				res_ch_q[1] <= '0;
				res_ch_q[2] <= '0;
				res_q_q     <= QUALITY_MIN;
			end else if (!smp_q_q[QUAL_W-1] && !in_band && smp_q_q > rd_q.q) begin
				res_act_q   <= ACT_REPLACED;
				res_ch_q[0] <= smp_r_q;
				res_ch_q[1] <= smp_g_q;
				res_ch_q[2] <= smp_b_q;
				res_q_q     <= smp_q_q;
			end else begin
				// ignored, or blended with the stored quality kept
				res_act_q   <= (!smp_q_q[QUAL_W-1] && in_band) ? ACT_BLENDED : ACT_IGNORED;
				res_ch_q[0] <= rd_q.r;
				res_ch_q[1] <= rd_q.g;
				res_ch_q[2] <= rd_q.b;
				res_q_q     <= rd_q.q;
			end
		end

		if (state_q == ST_DIV) begin
			rem_q <= q_bit ? rem_sub[WGT_W-1:0] : rem_sh[WGT_W-1:0];
			quo_q <= {quo_q[WGT_W-2:0], q_bit};
		end

		if (state_q == ST_MIX) begin
			res_ch_q[ch_q] <= mix_acc[23:16];
		end

		if (done_go) begin
			out_act_q  <= res_act_q;
			out_r_q    <= res_ch_q[0];
			out_g_q    <= res_ch_q[1];
			out_b_q    <= res_ch_q[2];
			out_qual_q <= res_q_q;
		end
	end

endmodule
